FILE: hw/rtl/usb_setup_request_decoder_macros.svh
// Assertion macros used by the USB setup request decoder RTL.
`ifndef USB_SETUP_REQUEST_DECODER_MACROS_SVH
`define USB_SETUP_REQUEST_DECODER_MACROS_SVH

// Same-cycle implication checked on every rising clock edge outside reset.
`define USBSRD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every rising clock edge outside reset.
`define USBSRD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/usbsrd_pkg.sv
// Package with the transaction types, codes and constants of the setup request decoder.
`default_nettype none
package usbsrd_pkg;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  request_type;
    logic [7:0]  request;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
  } in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] data_source;
    logic [7:0] data_length;
    logic [6:0] device_address;
    logic       address_enable;
  } out_t;

  typedef struct packed {
    logic [7:0] device_desc_length;
    logic [7:0] config_total_length;
    logic [7:0] config_value;
    logic [7:0] interface_number;
    logic [7:0] alt_setting;
  } cfg_t;

  typedef struct packed {
    logic [6:0] pending_address;
    logic       address_pending;
  } addr_state_t;

  localparam int unsigned PADDR_W = 5;

  localparam logic [2:0] REG_DEVICE_DESC_LENGTH  = 3'd0;
  localparam logic [2:0] REG_CONFIG_TOTAL_LENGTH = 3'd1;
  localparam logic [2:0] REG_CONFIG_VALUE        = 3'd2;
  localparam logic [2:0] REG_INTERFACE_NUMBER    = 3'd3;
  localparam logic [2:0] REG_ALT_SETTING         = 3'd4;

  localparam logic [7:0] RST_DEVICE_DESC_LENGTH  = 8'd18;
  localparam logic [7:0] RST_CONFIG_TOTAL_LENGTH = 8'd32;
  localparam logic [7:0] RST_CONFIG_VALUE        = 8'd1;
  localparam logic [7:0] RST_INTERFACE_NUMBER    = 8'd0;
  localparam logic [7:0] RST_ALT_SETTING         = 8'd0;

  localparam logic       OP_SETUP       = 1'b0;
  localparam logic       OP_STATUS_DONE = 1'b1;

  localparam logic [2:0] ACT_STALL   = 3'd0;
  localparam logic [2:0] ACT_DATA    = 3'd1;
  localparam logic [2:0] ACT_ZLP     = 3'd2;
  localparam logic [2:0] ACT_FORWARD = 3'd3;
  localparam logic [2:0] ACT_NONE    = 3'd4;

  localparam logic [1:0] SRC_STATUS   = 2'd0;
  localparam logic [1:0] SRC_DEVICE   = 2'd1;
  localparam logic [1:0] SRC_CONFIG   = 2'd2;
  localparam logic [1:0] SRC_CONFBYTE = 2'd3;

  localparam logic [7:0] RT_DEV_OUT  = 8'h00;
  localparam logic [7:0] RT_IF_OUT   = 8'h01;
  localparam logic [7:0] RT_EP_OUT   = 8'h02;
  localparam logic [7:0] RT_DEV_IN   = 8'h80;
  localparam logic [7:0] RT_IF_IN    = 8'h81;
  localparam logic [7:0] RT_EP_IN    = 8'h82;

  localparam logic [7:0] RQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] RQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] RQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] RQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] RQ_SET_DESCRIPTOR    = 8'd7;
  localparam logic [7:0] RQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] RQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] RQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] RQ_SET_INTERFACE     = 8'd11;
  localparam logic [7:0] RQ_SYNCH_FRAME       = 8'd12;

  localparam logic [7:0] DT_DEVICE = 8'd1;
  localparam logic [7:0] DT_CONFIG = 8'd2;

  localparam logic [7:0] STATUS_LEN  = 8'd2;
  localparam logic [7:0] CONFBYTE_LEN = 8'd1;
  localparam int unsigned DIR_BIT = 7;

endpackage
`default_nettype wire

FILE: hw/rtl/usbsrd_cfg_regs.sv
// APB-style configuration register file of the setup request decoder.
`default_nettype none
module usbsrd_cfg_regs
  import usbsrd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic       wr_en;
  logic [2:0] reg_sel;
  logic [7:0] rd_byte;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_desc_length  <= RST_DEVICE_DESC_LENGTH;
      cfg.config_total_length <= RST_CONFIG_TOTAL_LENGTH;
      cfg.config_value        <= RST_CONFIG_VALUE;
      cfg.interface_number    <= RST_INTERFACE_NUMBER;
      cfg.alt_setting         <= RST_ALT_SETTING;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DEVICE_DESC_LENGTH:  cfg.device_desc_length  <= pwdata[7:0];
        REG_CONFIG_TOTAL_LENGTH: cfg.config_total_length <= pwdata[7:0];
        REG_CONFIG_VALUE:        cfg.config_value        <= pwdata[7:0];
        REG_INTERFACE_NUMBER:    cfg.interface_number    <= pwdata[7:0];
        REG_ALT_SETTING:         cfg.alt_setting         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEVICE_DESC_LENGTH:  rd_byte = cfg.device_desc_length;
      REG_CONFIG_TOTAL_LENGTH: rd_byte = cfg.config_total_length;
      REG_CONFIG_VALUE:        rd_byte = cfg.config_value;
      REG_INTERFACE_NUMBER:    rd_byte = cfg.interface_number;
      REG_ALT_SETTING:         rd_byte = cfg.alt_setting;
      default:                 rd_byte = 8'd0;
    endcase
  end

  assign prdata = {24'd0, rd_byte};

endmodule
`default_nettype wire

FILE: hw/rtl/usbsrd_decode.sv
// Combinational decode of one setup or status transaction into a response and next address state.
`default_nettype none
module usbsrd_decode
  import usbsrd_pkg::*;
(
  input  wire in_t         item,
  input  wire cfg_t        cfg,
  input  wire addr_state_t addr_state,
  output out_t             result,
  output addr_state_t      addr_state_next
);

  logic [2:0]  action;
  logic [1:0]  src;
  logic [7:0]  dlen;
  logic        enable;
  logic        ok;
  logic [7:0]  dtype;
  logic [7:0]  didx;
  logic [7:0]  dev_clip;
  logic [7:0]  cfg_clip;

  assign dtype = item.value[15:8];
  assign didx  = item.value[7:0];
  assign dev_clip = (item.length < {8'd0, cfg.device_desc_length}) ?
                    item.length[7:0] : cfg.device_desc_length;
  assign cfg_clip = (item.length < {8'd0, cfg.config_total_length}) ?
                    item.length[7:0] : cfg.config_total_length;

  always_comb begin
    action          = ACT_NONE;
    src             = SRC_STATUS;
    dlen            = 8'd0;
    enable          = 1'b0;
    ok              = 1'b1;
    addr_state_next = addr_state;
    if (item.opcode == OP_STATUS_DONE) begin
      if (addr_state.address_pending) begin
        enable                          = 1'b1;
        addr_state_next.address_pending = 1'b0;
      end
    end else begin
      addr_state_next.address_pending = 1'b0;
      action = ACT_ZLP;
      unique case ({item.request_type, item.request})
        {RT_DEV_IN, RQ_GET_STATUS}: begin
          if (item.length != {8'd0, STATUS_LEN}) begin
            ok = 1'b0;
          end else begin
            action = ACT_DATA;
            src    = SRC_STATUS;
            dlen   = STATUS_LEN;
          end
        end
        {RT_DEV_OUT, RQ_CLEAR_FEATURE}: ;
        {RT_DEV_OUT, RQ_SET_ADDRESS}: begin
          addr_state_next.pending_address = item.value[6:0];
          addr_state_next.address_pending = 1'b1;
        end
        {RT_DEV_IN, RQ_GET_DESCRIPTOR}: begin
          if (dtype == DT_DEVICE) begin
            action = ACT_DATA;
            src    = SRC_DEVICE;
            dlen   = dev_clip;
          end else if (dtype == DT_CONFIG) begin
            if (didx != 8'd0) begin
              ok = 1'b0;
            end else begin
              action = ACT_DATA;
              src    = SRC_CONFIG;
              dlen   = cfg_clip;
            end
          end else begin
            action = ACT_FORWARD;
          end
        end
        {RT_DEV_IN, RQ_GET_CONFIGURATION}: begin
          action = ACT_DATA;
          src    = SRC_CONFBYTE;
          dlen   = CONFBYTE_LEN;
        end
        {RT_DEV_OUT, RQ_SET_CONFIGURATION}: begin
          if (item.value != {8'd0, cfg.config_value}) ok = 1'b0;
        end
        {RT_IF_OUT, RQ_SET_INTERFACE}: begin
          if (item.index != {8'd0, cfg.interface_number} ||
              item.value != {8'd0, cfg.alt_setting}) ok = 1'b0;
        end
        {RT_DEV_OUT, RQ_SET_FEATURE},
        {RT_DEV_OUT, RQ_SET_DESCRIPTOR},
        {RT_IF_IN,   RQ_GET_STATUS},
        {RT_IF_OUT,  RQ_CLEAR_FEATURE},
        {RT_IF_OUT,  RQ_SET_FEATURE},
        {RT_IF_IN,   RQ_GET_INTERFACE},
        {RT_EP_IN,   RQ_GET_STATUS},
        {RT_EP_OUT,  RQ_CLEAR_FEATURE},
        {RT_EP_OUT,  RQ_SET_FEATURE},
        {RT_EP_IN,   RQ_SYNCH_FRAME}: ok = 1'b0;
        default: action = ACT_FORWARD;
      endcase
      if (!ok) begin
        action = ACT_STALL;
        src    = SRC_STATUS;
        dlen   = 8'd0;
      end else if (action == ACT_ZLP && item.request_type[DIR_BIT]) begin
        action = ACT_NONE;
      end
    end
  end

  assign result.action         = action;
  assign result.data_source    = src;
  assign result.data_length    = dlen;
  assign result.device_address = addr_state_next.pending_address;
  assign result.address_enable = enable;

endmodule
`default_nettype wire

FILE: hw/rtl/usb_setup_request_decoder.sv
// Top level of the USB endpoint 0 standard setup request decoder.
// Each input transaction is either a setup packet or a notice that the
// status-stage IN transfer has completed, and each one yields exactly one
// result transaction with the chosen response and the device address state.
// Both channels use valid and ready; a transaction moves when both are high.
// An accepted input is held in an input register, decoded by shallow logic
// and written into the result register when that register is empty or its
// transaction is taken in the same cycle.
// The block takes one transaction per cycle for as long as results are taken.
// When the receiver stalls, the result register holds its transaction and one
// more input waits in the input register; then ready drops until room frees.
// The pending address and its flag update as a transaction enters the result
// register, so transactions see them strictly in order.
// Configuration registers sit on an APB-style port at byte addresses 4*i; the
// user writes them only while no transaction is in flight; the block does not enforce it.
// Reset empties both registers, clears the address state and loads the
// register defaults; the block is ready as soon as reset is released.
`default_nettype none
`include "usb_setup_request_decoder_macros.svh"
module usb_setup_request_decoder
  import usbsrd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_t                in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_t                    out_item,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  cfg_t        cfg;
  in_t         stage;
  logic        stage_valid;
  logic        advance;
  out_t        result;
  addr_state_t addr_state;
  addr_state_t addr_state_next;

  usbsrd_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  usbsrd_decode u_decode (
    .item            (stage),
    .cfg             (cfg),
    .addr_state      (addr_state),
    .result          (result),
    .addr_state_next (addr_state_next)
  );

  assign advance  = stage_valid & (~out_valid | out_ready);
  assign in_ready = ~stage_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      addr_state <= '0;
    end else if (advance) begin
      out_valid  <= 1'b1;
      addr_state <= addr_state_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  `USBSRD_ASSERT_NOW(a_enable_only_on_none, out_valid && out_item.address_enable, out_item.action == ACT_NONE, "address enable with an action other than none")
  `USBSRD_ASSERT_NOW(a_data_fields_zero, out_valid && out_item.action != ACT_DATA, out_item.data_source == SRC_STATUS && out_item.data_length == 8'd0, "data fields set without send data")
  `USBSRD_ASSERT_NEXT(a_stage_holds, stage_valid && !advance, stage_valid && $stable(stage), "input register lost a waiting transaction")
  `USBSRD_ASSERT_NEXT(a_status_clears_pending, advance && stage.opcode == OP_STATUS_DONE && addr_state.address_pending, !addr_state.address_pending && out_item.address_enable, "status done did not enable the pending address")

endmodule
`default_nettype wire

FILE: test/tb_usb_setup_request_decoder.sv
// Self-checking testbench for the USB setup request decoder with a built-in decode predictor.
module tb_usb_setup_request_decoder;
  import usbsrd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  usb_setup_request_decoder uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  in_t pending_requests[$];
  out_t expected_responses[$];

  cfg_t cfg = '{RST_DEVICE_DESC_LENGTH, RST_CONFIG_TOTAL_LENGTH, RST_CONFIG_VALUE,
                RST_INTERFACE_NUMBER, RST_ALT_SETTING};
  logic [6:0] addr_latch = '0;
  logic addr_armed = 1'b0;

  int error_count = 0;
  int cycle_count = 0;
  int requests_sent = 0;
  int responses_seen = 0;
  int data_seen = 0;
  int stalls_seen = 0;
  int forwards_seen = 0;
  int enables_seen = 0;
  int settings_used = 1;

  int req_gap_left = 0;
  bit req_quiet = 1'b0;
  int resp_stall_left = 0;
  bit resp_quiet = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= 40) begin
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h (response %0d)",
               what, got, want, responses_seen);
    end
  endtask

  function automatic logic [7:0] clip_len(input logic [7:0] size, input logic [15:0] limit);
    return (limit < {8'h00, size}) ? limit[7:0] : size;
  endfunction

  function automatic out_t decode_request(input in_t rq);
    out_t rsp;
    logic reject;
    rsp = '0;
    rsp.action = ACT_NONE;
    reject = 1'b0;
    if (rq.opcode == OP_STATUS_DONE) begin
      if (addr_armed) begin
        rsp.address_enable = 1'b1;
        addr_armed = 1'b0;
      end
    end else begin
      addr_armed = 1'b0;
      rsp.action = ACT_ZLP;
      case ({rq.request, rq.request_type})
        {RQ_GET_STATUS, RT_DEV_IN}: begin
          if (rq.length != {8'h00, STATUS_LEN}) begin
            reject = 1'b1;
          end else begin
            rsp.action = ACT_DATA;
            rsp.data_source = SRC_STATUS;
            rsp.data_length = STATUS_LEN;
          end
        end
        {RQ_CLEAR_FEATURE, RT_DEV_OUT}: begin
        end
        {RQ_SET_ADDRESS, RT_DEV_OUT}: begin
          addr_latch = rq.value[6:0];
          addr_armed = 1'b1;
        end
        {RQ_GET_DESCRIPTOR, RT_DEV_IN}: begin
          if (rq.value[15:8] == DT_DEVICE) begin
            rsp.action = ACT_DATA;
            rsp.data_source = SRC_DEVICE;
            rsp.data_length = clip_len(cfg.device_desc_length, rq.length);
          end else if (rq.value[15:8] == DT_CONFIG) begin
            if (rq.value[7:0] != 8'h00) begin
              reject = 1'b1;
            end else begin
              rsp.action = ACT_DATA;
              rsp.data_source = SRC_CONFIG;
              rsp.data_length = clip_len(cfg.config_total_length, rq.length);
            end
          end else begin
            rsp.action = ACT_FORWARD;
          end
        end
        {RQ_GET_CONFIGURATION, RT_DEV_IN}: begin
          rsp.action = ACT_DATA;
          rsp.data_source = SRC_CONFBYTE;
          rsp.data_length = CONFBYTE_LEN;
        end
        {RQ_SET_CONFIGURATION, RT_DEV_OUT}: begin
          if (rq.value != {8'h00, cfg.config_value}) reject = 1'b1;
        end
        {RQ_SET_INTERFACE, RT_IF_OUT}: begin
          if (rq.index != {8'h00, cfg.interface_number} ||
              rq.value != {8'h00, cfg.alt_setting}) reject = 1'b1;
        end
        {RQ_SET_FEATURE, RT_DEV_OUT}, {RQ_SET_DESCRIPTOR, RT_DEV_OUT},
        {RQ_GET_STATUS, RT_IF_IN}, {RQ_CLEAR_FEATURE, RT_IF_OUT},
        {RQ_SET_FEATURE, RT_IF_OUT}, {RQ_GET_INTERFACE, RT_IF_IN},
        {RQ_GET_STATUS, RT_EP_IN}, {RQ_CLEAR_FEATURE, RT_EP_OUT},
        {RQ_SET_FEATURE, RT_EP_OUT}, {RQ_SYNCH_FRAME, RT_EP_IN}: begin
          reject = 1'b1;
        end
        default: begin
          rsp.action = ACT_FORWARD;
        end
      endcase
      if (reject) begin
        rsp.action = ACT_STALL;
        rsp.data_source = SRC_STATUS;
        rsp.data_length = 8'h00;
      end else if (rsp.action == ACT_ZLP && rq.request_type[DIR_BIT]) begin
        rsp.action = ACT_NONE;
      end
    end
    rsp.device_address = addr_latch;
    return rsp;
  endfunction

  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 31) == 0) quiet = ~quiet;
    return quiet ? 0 : int'($urandom_range(0, 7));
  endfunction

  function automatic in_t random_fields();
    in_t rq;
    rq.opcode = 1'($urandom_range(0, 1));
    rq.request_type = 8'($urandom);
    rq.request = 8'($urandom);
    rq.value = 16'($urandom);
    rq.index = 16'($urandom);
    rq.length = 16'($urandom);
    return rq;
  endfunction

  function automatic in_t make_item(input logic op, input logic [7:0] rt, input logic [7:0] rq,
                                    input logic [15:0] val, input logic [15:0] idx,
                                    input logic [15:0] len);
    return '{op, rt, rq, val, idx, len};
  endfunction

  function automatic logic [7:0] extreme_byte();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      3: return 8'h12;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic apb_write(input logic [2:0] reg_idx, input logic [7:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {24'h000000, data};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || in_valid || expected_responses.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    logic holding;
    if (rst) begin
      in_valid <= 1'b0;
      req_gap_left = 0;
    end else begin
      holding = in_valid;
      if (in_valid && in_ready) begin
        expected_responses.push_back(decode_request(in_item));
        requests_sent++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (req_gap_left != 0) begin
          req_gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_item <= pending_requests.pop_front();
          in_valid <= 1'b1;
          req_gap_left = draw_wait(req_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
      resp_stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        responses_seen++;
        if (expected_responses.size() == 0) begin
          report_mismatch("unexpected response", int'(out_item), 0);
        end else begin
          want = expected_responses.pop_front();
          if (out_item.action !== want.action)
            report_mismatch("action", int'(out_item.action), int'(want.action));
          if (out_item.data_source !== want.data_source)
            report_mismatch("data_source", int'(out_item.data_source),
                            int'(want.data_source));
          if (out_item.data_length !== want.data_length)
            report_mismatch("data_length", int'(out_item.data_length),
                            int'(want.data_length));
          if (out_item.device_address !== want.device_address)
            report_mismatch("device_address", int'(out_item.device_address),
                            int'(want.device_address));
          if (out_item.address_enable !== want.address_enable)
            report_mismatch("address_enable", int'(out_item.address_enable),
                            int'(want.address_enable));
          if (want.action == ACT_DATA) data_seen++;
          if (want.action == ACT_STALL) stalls_seen++;
          if (want.action == ACT_FORWARD) forwards_seen++;
          if (want.address_enable) enables_seen++;
        end
        resp_stall_left = draw_wait(resp_quiet);
      end
      if (resp_stall_left != 0) begin
        resp_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_responses.size() + pending_requests.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_t rq;
    cfg_t setting;
    int queued;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    pending_requests.push_back(make_item(OP_STATUS_DONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                                         16'hFFFF));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_OUT, RQ_SET_ADDRESS, 16'hFFFF,
                                         16'hFFFF, 16'hFFFF));
    pending_requests.push_back(make_item(OP_STATUS_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                                         16'h0000));
    pending_requests.push_back(make_item(OP_STATUS_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                                         16'h0000));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_OUT, RQ_SET_ADDRESS, 16'h0005,
                                         16'h0000, 16'h0000));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_IN, RQ_GET_DESCRIPTOR,
                                         {DT_DEVICE, 8'h00}, 16'h0000, 16'hFFFF));
    pending_requests.push_back(make_item(OP_STATUS_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                                         16'h0000));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_IN, RQ_GET_STATUS, 16'h0000,
                                         16'h0000, {8'h00, STATUS_LEN}));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_IN, RQ_GET_STATUS, 16'h0000,
                                         16'h0000, 16'h0003));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_IN, RQ_GET_STATUS, 16'h0000,
                                         16'h0000, 16'h0000));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_IN, RQ_GET_DESCRIPTOR,
                                         {DT_DEVICE, 8'h00}, 16'h0000, 16'h0005));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_IN, RQ_GET_DESCRIPTOR,
                                         {DT_CONFIG, 8'h00}, 16'h0000, 16'h0000));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_IN, RQ_GET_DESCRIPTOR,
                                         {DT_CONFIG, 8'h01}, 16'h0000, 16'hFFFF));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_IN, RQ_GET_DESCRIPTOR, 16'h0300,
                                         16'h0409, 16'h00FF));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_IN, RQ_GET_CONFIGURATION, 16'h0000,
                                         16'h0000, 16'h0000));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_OUT, RQ_SET_CONFIGURATION,
                                         {8'h00, RST_CONFIG_VALUE}, 16'h0000, 16'h0000));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_OUT, RQ_SET_CONFIGURATION, 16'h0101,
                                         16'h0000, 16'h0000));
    pending_requests.push_back(make_item(OP_SETUP, RT_IF_OUT, RQ_SET_INTERFACE, 16'h0000,
                                         16'h0000, 16'h0000));
    pending_requests.push_back(make_item(OP_SETUP, RT_IF_OUT, RQ_SET_INTERFACE, 16'h0000,
                                         16'h0001, 16'h0000));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_OUT, RQ_CLEAR_FEATURE, 16'h0001,
                                         16'h0000, 16'h0000));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_OUT, RQ_SET_FEATURE, 16'h0001,
                                         16'h0000, 16'h0000));
    pending_requests.push_back(make_item(OP_SETUP, RT_EP_IN, RQ_SYNCH_FRAME, 16'h0000,
                                         16'h0081, 16'h0002));
    pending_requests.push_back(make_item(OP_SETUP, 8'h40, 8'h01, 16'h1234, 16'h5678,
                                         16'h0040));
    pending_requests.push_back(make_item(OP_SETUP, RT_DEV_OUT, RQ_SET_ADDRESS, 16'h0000,
                                         16'h0000, 16'h0000));
    pending_requests.push_back(make_item(OP_STATUS_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                                         16'h0000));
    drain();

    for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
      case (phase)
        1: setting = '0;
        2: setting = '1;
        default: setting = '{extreme_byte(), extreme_byte(), extreme_byte(),
                             extreme_byte(), extreme_byte()};
      endcase
      apb_write(REG_DEVICE_DESC_LENGTH, setting.device_desc_length);
      apb_write(REG_CONFIG_TOTAL_LENGTH, setting.config_total_length);
      apb_write(REG_CONFIG_VALUE, setting.config_value);
      apb_write(REG_INTERFACE_NUMBER, setting.interface_number);
      apb_write(REG_ALT_SETTING, setting.alt_setting);
      cfg = setting;
      settings_used++;

      queued = 0;
      while (queued < ITEMS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0: begin
            rq = random_fields();
            rq.opcode = OP_STATUS_DONE;
            pending_requests.push_back(rq);
            queued++;
          end
          1: begin
            rq = random_fields();
            rq.opcode = OP_SETUP;
            pending_requests.push_back(rq);
            queued++;
          end
          2: begin
            rq = random_fields();
            rq.opcode = OP_SETUP;
            {rq.request, rq.request_type} = {RQ_SET_ADDRESS, RT_DEV_OUT};
            pending_requests.push_back(rq);
            rq = random_fields();
            if ($urandom_range(0, 3) != 0) rq.opcode = OP_STATUS_DONE;
            pending_requests.push_back(rq);
            queued += 2;
          end
          default: begin
            rq = random_fields();
            rq.opcode = OP_SETUP;
            case ($urandom_range(0, 18))
              0: {rq.request, rq.request_type} = {RQ_GET_STATUS, RT_DEV_IN};
              1: {rq.request, rq.request_type} = {RQ_CLEAR_FEATURE, RT_DEV_OUT};
              2: {rq.request, rq.request_type} = {RQ_SET_ADDRESS, RT_DEV_OUT};
              3, 4, 5: {rq.request, rq.request_type} = {RQ_GET_DESCRIPTOR, RT_DEV_IN};
              6: {rq.request, rq.request_type} = {RQ_GET_CONFIGURATION, RT_DEV_IN};
              7: {rq.request, rq.request_type} = {RQ_SET_CONFIGURATION, RT_DEV_OUT};
              8: {rq.request, rq.request_type} = {RQ_SET_INTERFACE, RT_IF_OUT};
              9: {rq.request, rq.request_type} = {RQ_SET_FEATURE, RT_DEV_OUT};
              10: {rq.request, rq.request_type} = {RQ_SET_DESCRIPTOR, RT_DEV_OUT};
              11: {rq.request, rq.request_type} = {RQ_GET_STATUS, RT_IF_IN};
              12: {rq.request, rq.request_type} = {RQ_CLEAR_FEATURE, RT_IF_OUT};
              13: {rq.request, rq.request_type} = {RQ_SET_FEATURE, RT_IF_OUT};
              14: {rq.request, rq.request_type} = {RQ_GET_INTERFACE, RT_IF_IN};
              15: {rq.request, rq.request_type} = {RQ_GET_STATUS, RT_EP_IN};
              16: {rq.request, rq.request_type} = {RQ_CLEAR_FEATURE, RT_EP_OUT};
              17: {rq.request, rq.request_type} = {RQ_SET_FEATURE, RT_EP_OUT};
              default: {rq.request, rq.request_type} = {RQ_SYNCH_FRAME, RT_EP_IN};
            endcase
            case ($urandom_range(0, 5))
              0: rq.length = 16'h0000;
              1: rq.length = {8'h00, STATUS_LEN};
              2: rq.length = 16'($urandom_range(1, 3));
              3: rq.length = 16'($urandom_range(0, 300));
              4: rq.length = 16'hFFFF;
              default: begin
              end
            endcase
            if ({rq.request, rq.request_type} == {RQ_GET_DESCRIPTOR, RT_DEV_IN}) begin
              case ($urandom_range(0, 2))
                0: rq.value[15:8] = DT_DEVICE;
                1: rq.value[15:8] = DT_CONFIG;
                default: begin
                end
              endcase
              if ($urandom_range(0, 3) != 0) rq.value[7:0] = 8'h00;
            end else if ({rq.request, rq.request_type} ==
                         {RQ_SET_CONFIGURATION, RT_DEV_OUT}) begin
              if ($urandom_range(0, 3) != 0) rq.value = {8'h00, cfg.config_value};
            end else if ({rq.request, rq.request_type} == {RQ_SET_INTERFACE, RT_IF_OUT}) begin
              if ($urandom_range(0, 3) != 0) rq.index = {8'h00, cfg.interface_number};
              if ($urandom_range(0, 3) != 0) rq.value = {8'h00, cfg.alt_setting};
            end
            if ($urandom_range(0, 9) == 0) begin
              rq.request_type[3'($urandom_range(0, 7))] ^= 1'b1;
            end
            pending_requests.push_back(rq);
            queued++;
          end
        endcase
      end
      drain();
    end

    $display("Checked %0d responses to %0d requests under %0d register settings.",
             responses_seen, requests_sent, settings_used);
    $display("Seen: %0d data, %0d stall, %0d forward, %0d address enable responses.",
             data_seen, stalls_seen, forwards_seen, enables_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
